// File: hw/rtl/index_to_candidate_string_assert.svh
// Assertion macros used by the RTL file that carries checks.
// Each macro needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef INDEX_TO_CANDIDATE_STRING_ASSERT_SVH
`define INDEX_TO_CANDIDATE_STRING_ASSERT_SVH

`ifndef SYNTH

// Holds in the same cycle: antecedent implies consequent.
`define ITCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Delayed check: antecedent implies consequent on the next edge.
`define ITCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ITCS_ASSERT_SAME(label, ante, cons, msg)
`define ITCS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/itcs_pkg.sv
package itcs_pkg;

  localparam int CHARSET_MAX = 128;
  localparam int DIGITS_MAX  = 16;
  localparam int PREFIX_MAX  = 16;

  localparam int TABLE_AW  = $clog2(CHARSET_MAX);
  localparam int PREFIX_AW = $clog2(PREFIX_MAX);

  localparam int QUEUE_DEPTH = 2;

  // Input opcodes, also used as the command kind in the queue.
  localparam logic [1:0] OP_WR_CHAR   = 2'd0;
  localparam logic [1:0] OP_WR_PREFIX = 2'd1;
  localparam logic [1:0] OP_CONVERT   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CHARSET_LEN = 2'd0;
  localparam logic [1:0] REG_DIGIT_LEN   = 2'd1;
  localparam logic [1:0] REG_PREFIX_LEN  = 2'd2;

  localparam logic [7:0] CHARSET_LEN_RST = 8'd62;
  localparam logic [4:0] DIGIT_LEN_RST   = 5'd8;
  localparam logic [4:0] PREFIX_LEN_RST  = 5'd0;

  localparam logic [7:0] RADIX_MIN = 8'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  entry_index;
    logic [7:0]  entry_byte;
    logic [63:0] candidate_index;
  } cmd_t;

  // Configuration after range limiting.
  typedef struct packed {
    logic [7:0] radix;
    logic [4:0] digits;
    logic [4:0] plen;
  } conv_cfg_t;

  typedef struct packed {
    logic idle;
    logic div_busy;
  } back_status_t;

endpackage

// File: hw/rtl/index_to_candidate_string.sv
// Candidate string generator for keyspace enumeration.
// Input channel (in_): one item per command. in_tuser carries the opcode:
// write a character table entry, write a prefix byte, or convert an index.
// Load items produce no output. A convert item produces the configured
// number of prefix bytes followed by the configured number of generated
// characters, one output item per byte, with out_tlast set on the final
// byte. Configuration (cfg_) writes the radix, digit count and prefix length
// and is accepted every cycle; it may only change while nothing is in flight.
// Each prefix byte takes a memory read, then an output step. Each generated
// character takes a divider start, a wait while the divider retires eight
// quotient bits a cycle over the 64-bit index, then the character table
// read and the output step. A two-entry queue between the front end and the
// back end lets new items be accepted while a conversion is running. When
// out_tready is low the output register holds its byte and the back end
// waits before emitting. Reset clears the queue, sequencer and output valid
// and restores the default configuration; table and prefix contents are
// kept as they are and must be written before they are used.
`include "index_to_candidate_string_assert.svh"

module index_to_candidate_string (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: entry_index[6:0], entry_byte[14:7],
  // candidate_index[78:15], zero pad [79].
  input  logic [79:0] in_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [1:0]  in_tuser,
  // Output items.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: out_byte[7:0], position[12:8], zero pad [15:13].
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] charset_len_r;
  logic [4:0] digit_len_r;
  logic [4:0] prefix_len_r;

  itcs_pkg::conv_cfg_t    conv_cfg;
  itcs_pkg::cmd_t         q_cmd;
  itcs_pkg::back_status_t back_status;
  logic                   q_valid, q_pop;
  logic [7:0]             out_byte;
  logic [4:0]             out_position;

  // Configuration registers. Writes to an index beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_len_r <= itcs_pkg::CHARSET_LEN_RST;
      digit_len_r   <= itcs_pkg::DIGIT_LEN_RST;
      prefix_len_r  <= itcs_pkg::PREFIX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        itcs_pkg::REG_CHARSET_LEN: charset_len_r <= cfg_data;
        itcs_pkg::REG_DIGIT_LEN:   digit_len_r   <= cfg_data[4:0];
        itcs_pkg::REG_PREFIX_LEN:  prefix_len_r  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are limited to what the stores and divider support.
  always_comb begin
    if (charset_len_r < itcs_pkg::RADIX_MIN) begin
      conv_cfg.radix = itcs_pkg::RADIX_MIN;
    end else if (32'(charset_len_r) > itcs_pkg::CHARSET_MAX) begin
      conv_cfg.radix = 8'(itcs_pkg::CHARSET_MAX);
    end else begin
      conv_cfg.radix = charset_len_r;
    end
    if (32'(digit_len_r) > itcs_pkg::DIGITS_MAX) begin
      conv_cfg.digits = 5'(itcs_pkg::DIGITS_MAX);
    end else begin
      conv_cfg.digits = digit_len_r;
    end
    if (32'(prefix_len_r) > itcs_pkg::PREFIX_MAX) begin
      conv_cfg.plen = 5'(itcs_pkg::PREFIX_MAX);
    end else begin
      conv_cfg.plen = prefix_len_r;
    end
  end

  // Front end: accepts items, drops the ones that do nothing, queues the rest.
  itcs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_opcode          (in_tuser),
    .in_entry_index     (in_tdata[6:0]),
    .in_entry_byte      (in_tdata[14:7]),
    .in_candidate_index (in_tdata[78:15]),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop)
  );

  // Back end: performs loads, reads the prefix, and runs the digit loop.
  itcs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (conv_cfg),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_byte     (out_byte),
    .out_position (out_position),
    .out_last     (out_tlast),
    .status       (back_status)
  );

  assign out_tdata = {3'b000, out_position, out_byte};

  // A byte that is not the last one means the conversion is still running.
  `ITCS_ASSERT_SAME(a_nonlast_busy, out_tvalid && !out_tlast, !back_status.idle, "nonlast byte while idle")
  // The divider only runs on behalf of an active conversion.
  `ITCS_ASSERT_SAME(a_div_owned, back_status.div_busy, !back_status.idle, "divider busy while idle")
  // A byte waiting at the output cannot be lost while the sequencer works.
  `ITCS_ASSERT_NEXT(a_out_held, out_tvalid && !out_tready && !out_tlast, out_tvalid, "output byte dropped")

endmodule

// File: hw/rtl/itcs_ram.sv
module itcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/itcs_div.sv
module itcs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic [63:0] quotient,
  output logic [7:0]  remainder
);

  // Restoring division, eight quotient bits per cycle over the 64-bit dividend.
  localparam int BITS_PER_CYCLE = 8;

  logic [63:0] quot_r, quot_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] step_q;
  logic [7:0]  step_r;

  always_comb begin
    step_q = quot_r;
    step_r = rem_r;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      step_r = {step_r[6:0], step_q[63]};
      step_q = {step_q[62:0], 1'b0};
      if (step_r >= divisor) begin
        step_r    = step_r - divisor;
        step_q[0] = 1'b1;
      end
    end
  end

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = 8'd0;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = step_q;
      rem_nxt  = step_r;
      cnt_nxt  = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/itcs_front.sv
module itcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_opcode,
  input  logic [6:0]          in_entry_index,
  input  logic [7:0]          in_entry_byte,
  input  logic [63:0]         in_candidate_index,
  output logic                q_valid,
  output itcs_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);

  localparam int PTR_W = $clog2(itcs_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(itcs_pkg::QUEUE_DEPTH + 1);

  itcs_pkg::cmd_t   mem_r [itcs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept, keep, push;
  itcs_pkg::cmd_t   cmd;

  assign in_tready = (count_r != CNT_W'(itcs_pkg::QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // Opcode three and loads beyond a store's depth are taken and dropped.
  always_comb begin
    unique case (in_opcode)
      itcs_pkg::OP_WR_CHAR:   keep = (32'(in_entry_index) < itcs_pkg::CHARSET_MAX);
      itcs_pkg::OP_WR_PREFIX: keep = (32'(in_entry_index) < itcs_pkg::PREFIX_MAX);
      itcs_pkg::OP_CONVERT:   keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign cmd.kind            = in_opcode;
  assign cmd.entry_index     = in_entry_index;
  assign cmd.entry_byte      = in_entry_byte;
  assign cmd.candidate_index = in_candidate_index;

  assign push = accept && keep;

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
    end
    if (push) begin
      mem_r[wptr_r] <= cmd;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rptr_r];

endmodule

// File: hw/rtl/itcs_back.sv
module itcs_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  itcs_pkg::conv_cfg_t     cfg,
  input  logic                    q_valid,
  input  itcs_pkg::cmd_t          q_cmd,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_byte,
  output logic [4:0]              out_position,
  output logic                    out_last,
  output itcs_pkg::back_status_t  status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRD    = 3'd1;
  localparam logic [2:0] S_POUT   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_TRD    = 3'd5;
  localparam logic [2:0] S_TOUT   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [63:0] q_r, q_nxt;
  logic [itcs_pkg::PREFIX_AW-1:0] idx_r, idx_nxt;
  logic [4:0]  dleft_r, dleft_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [5:0]  total_r, total_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic [4:0]  opos_r, opos_nxt;
  logic        olast_r, olast_nxt;

  logic        out_free, pos_last, prefix_done;
  logic        table_wr, prefix_wr, table_rd, prefix_rd;
  logic [7:0]  table_rdata, prefix_rdata;
  logic        div_start, div_busy;
  logic [63:0] div_quot;
  logic [7:0]  div_rem;

  assign out_free    = !ovalid_r || out_tready;
  assign pos_last    = ({1'b0, pos_r} + 6'd1 == total_r);
  assign prefix_done = (5'({1'b0, idx_r}) + 5'd1 == cfg.plen);

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign table_wr  = q_pop && (q_cmd.kind == itcs_pkg::OP_WR_CHAR);
  assign prefix_wr = q_pop && (q_cmd.kind == itcs_pkg::OP_WR_PREFIX);
  assign prefix_rd = (state_r == S_PRD);
  assign table_rd  = (state_r == S_TRD);
  assign div_start = (state_r == S_DSTART);

  itcs_ram #(
    .WIDTH (8),
    .DEPTH (itcs_pkg::CHARSET_MAX)
  ) u_table (
    .clk     (clk),
    .wr_en   (table_wr),
    .wr_addr (q_cmd.entry_index[itcs_pkg::TABLE_AW-1:0]),
    .wr_data (q_cmd.entry_byte),
    .rd_en   (table_rd),
    .rd_addr (div_rem[itcs_pkg::TABLE_AW-1:0]),
    .rd_data (table_rdata)
  );

  itcs_ram #(
    .WIDTH (8),
    .DEPTH (itcs_pkg::PREFIX_MAX)
  ) u_prefix (
    .clk     (clk),
    .wr_en   (prefix_wr),
    .wr_addr (q_cmd.entry_index[itcs_pkg::PREFIX_AW-1:0]),
    .wr_data (q_cmd.entry_byte),
    .rd_en   (prefix_rd),
    .rd_addr (idx_r),
    .rd_data (prefix_rdata)
  );

  itcs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (q_r),
    .divisor   (cfg.radix),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    q_nxt      = q_r;
    idx_nxt    = idx_r;
    dleft_nxt  = dleft_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    opos_nxt   = opos_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && (q_cmd.kind == itcs_pkg::OP_CONVERT)) begin
          q_nxt     = q_cmd.candidate_index;
          idx_nxt   = '0;
          pos_nxt   = 5'd0;
          dleft_nxt = cfg.digits;
          total_nxt = {1'b0, cfg.plen} + {1'b0, cfg.digits};
          if (cfg.plen != 5'd0) begin
            state_nxt = S_PRD;
          end else if (cfg.digits != 5'd0) begin
            state_nxt = S_DSTART;
          end
        end
      end
      S_PRD: begin
        state_nxt = S_POUT;
      end
      S_POUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = prefix_rdata;
          opos_nxt   = pos_r;
          olast_nxt  = pos_last;
          pos_nxt    = pos_r + 5'd1;
          idx_nxt    = idx_r + itcs_pkg::PREFIX_AW'(1);
          if (!prefix_done) begin
            state_nxt = S_PRD;
          end else if (dleft_r != 5'd0) begin
            state_nxt = S_DSTART;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          q_nxt     = div_quot;
          state_nxt = S_TRD;
        end
      end
      S_TRD: begin
        state_nxt = S_TOUT;
      end
      S_TOUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = table_rdata;
          opos_nxt   = pos_r;
          olast_nxt  = pos_last;
          pos_nxt    = pos_r + 5'd1;
          dleft_nxt  = dleft_r - 5'd1;
          state_nxt  = (dleft_r == 5'd1) ? S_IDLE : S_DSTART;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      q_r      <= 64'd0;
      dleft_r  <= 5'd0;
      pos_r    <= 5'd0;
      total_r  <= 6'd0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      q_r      <= q_nxt;
      dleft_r  <= dleft_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      idx_r    <= idx_nxt;
    end
    obyte_r <= obyte_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid   = ovalid_r;
  assign out_byte     = obyte_r;
  assign out_position = opos_r;
  assign out_last     = olast_r;

  assign status.idle     = (state_r == S_IDLE);
  assign status.div_busy = div_busy;

endmodule
